// ===== rtl/pecmp_pkg.sv =====
// Shared types, constants and section codes for the chunked message parser.
package pecmp_pkg;

  localparam int BYTE_W   = 8;
  localparam int V7_W     = 7;
  localparam int WORD_W   = 14;
  localparam int ID_W     = 28;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int OP_W     = 4;
  localparam int IDX_W    = 3;

  // Section codes; the byte kind reported for a byte is the section it fell in.
  localparam logic [KIND_W-1:0] SEC_COMMON  = 3'd0;
  localparam logic [KIND_W-1:0] SEC_REQID   = 3'd1;
  localparam logic [KIND_W-1:0] SEC_HDRLEN  = 3'd2;
  localparam logic [KIND_W-1:0] SEC_HDRDATA = 3'd3;
  localparam logic [KIND_W-1:0] SEC_WORDS   = 3'd4;
  localparam logic [KIND_W-1:0] SEC_PROP    = 3'd5;
  localparam logic [KIND_W-1:0] SEC_DONE    = 3'd6;

  localparam logic [STATUS_W-1:0] ST_BUSY  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EARLY = 2'd2;

  // Field write operations passed from the front to the back.
  localparam logic [OP_W-1:0] OP_NONE = 4'd0;
  localparam logic [OP_W-1:0] OP_TYPE = 4'd1;
  localparam logic [OP_W-1:0] OP_FMT  = 4'd2;
  localparam logic [OP_W-1:0] OP_ID   = 4'd3;
  localparam logic [OP_W-1:0] OP_REQ  = 4'd4;
  localparam logic [OP_W-1:0] OP_HLEN = 4'd5;
  localparam logic [OP_W-1:0] OP_NCH  = 4'd6;
  localparam logic [OP_W-1:0] OP_CNUM = 4'd7;
  localparam logic [OP_W-1:0] OP_DLEN = 4'd8;

  localparam int POS_W       = 4;
  localparam int COMMON_LEN  = 13;
  localparam int WORD_BYTES  = 6;
  localparam int CMDQ_DEPTH  = 4;
  localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
  localparam int OUTQ_DEPTH  = 2;
  localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]   byte_kind;
    logic [BYTE_W-1:0]   payload_byte;
    logic [STATUS_W-1:0] status;
    logic [V7_W-1:0]     message_type;
    logic [V7_W-1:0]     message_format;
    logic [ID_W-1:0]     source_id;
    logic [ID_W-1:0]     dest_id;
    logic [V7_W-1:0]     request_id;
    logic [WORD_W-1:0]   header_length;
    logic [WORD_W-1:0]   chunk_count;
    logic [WORD_W-1:0]   chunk_number;
    logic [WORD_W-1:0]   data_length;
  } out_item_t;

  // One classified byte: what to report and which field to write.
  typedef struct packed {
    logic [BYTE_W-1:0]   payload_byte;
    logic [KIND_W-1:0]   byte_kind;
    logic [STATUS_W-1:0] status;
    logic                eom;
    logic [OP_W-1:0]     op;
    logic [IDX_W-1:0]    op_idx;
    logic [WORD_W-1:0]   op_val;
  } cmd_t;

endpackage

// ===== rtl/pecmp_front.sv =====
// Front end: walks the frame sections and classifies each accepted byte.
module pecmp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  pecmp_pkg::in_item_t in_item,
  output pecmp_pkg::cmd_t    cmd
);
  import pecmp_pkg::*;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [KIND_W-1:0] sec_r, sec_nxt;
  logic [WORD_W-1:0] left_r, left_nxt;
  logic [V7_W-1:0]   hold_r, hold_nxt;

  logic [V7_W-1:0]   v;
  logic [WORD_W-1:0] word;
  logic [IDX_W-1:0]  l3;
  logic [IDX_W-1:0]  widx;

  assign v    = in_item.data_byte[V7_W-1:0];
  assign word = {v, hold_r};

  always_comb begin
    sec_nxt  = sec_r;
    left_nxt = left_r;
    hold_nxt = hold_r;
    cmd.payload_byte = in_item.data_byte;
    cmd.byte_kind    = sec_r;
    cmd.eom          = in_item.end_of_message;
    cmd.op           = OP_NONE;
    cmd.op_idx       = '0;
    cmd.op_val       = {{(WORD_W-V7_W){1'b0}}, v};
    // A word-section count outside 1..6 is treated as the last word byte.
    l3   = (left_r > WORD_W'(WORD_BYTES) || left_r == '0) ? IDX_W'(1) : left_r[IDX_W-1:0];
    widx = IDX_W'(WORD_BYTES) - l3;
    unique case (sec_r)
      SEC_COMMON: begin
        if (pos_r == POS_W'(3)) begin
          cmd.op = OP_TYPE;
        end else if (pos_r == POS_W'(4)) begin
          cmd.op = OP_FMT;
        end else if (pos_r >= POS_W'(5) && pos_r <= POS_W'(COMMON_LEN-1)) begin
          cmd.op     = OP_ID;
          cmd.op_idx = IDX_W'(pos_r - POS_W'(5));
        end
        if (pos_r >= POS_W'(COMMON_LEN-1)) begin
          sec_nxt = SEC_REQID;
        end
      end
      SEC_REQID: begin
        cmd.op   = OP_REQ;
        sec_nxt  = SEC_HDRLEN;
        left_nxt = WORD_W'(2);
      end
      SEC_HDRLEN: begin
        if (left_r >= WORD_W'(2)) begin
          hold_nxt = v;
          left_nxt = WORD_W'(1);
        end else begin
          cmd.op     = OP_HLEN;
          cmd.op_val = word;
          if (word != '0) begin
            sec_nxt  = SEC_HDRDATA;
            left_nxt = word;
          end else begin
            sec_nxt  = SEC_WORDS;
            left_nxt = WORD_W'(WORD_BYTES);
          end
        end
      end
      SEC_HDRDATA: begin
        if (left_r <= WORD_W'(1)) begin
          sec_nxt  = SEC_WORDS;
          left_nxt = WORD_W'(WORD_BYTES);
        end else begin
          left_nxt = left_r - WORD_W'(1);
        end
      end
      SEC_WORDS: begin
        if (!widx[0]) begin
          hold_nxt = v;
        end else begin
          cmd.op_val = word;
          if (widx == IDX_W'(1)) begin
            cmd.op = OP_NCH;
          end else if (widx == IDX_W'(3)) begin
            cmd.op = OP_CNUM;
          end else begin
            cmd.op = OP_DLEN;
          end
        end
        // The last word byte always completes the data length word.
        if (l3 <= IDX_W'(1)) begin
          if (word != '0) begin
            sec_nxt  = SEC_PROP;
            left_nxt = word;
          end else begin
            sec_nxt  = SEC_DONE;
            left_nxt = '0;
          end
        end else begin
          left_nxt = WORD_W'(l3 - IDX_W'(1));
        end
      end
      SEC_PROP: begin
        if (left_r <= WORD_W'(1)) begin
          sec_nxt  = SEC_DONE;
          left_nxt = '0;
        end else begin
          left_nxt = left_r - WORD_W'(1);
        end
      end
      default: begin
        sec_nxt  = SEC_DONE;
        left_nxt = '0;
      end
    endcase
    cmd.status = in_item.end_of_message ? ((sec_nxt == SEC_DONE) ? ST_DONE : ST_EARLY)
                                        : ST_BUSY;
    if (pos_r != '1) begin
      pos_nxt = pos_r + POS_W'(1);
    end else begin
      pos_nxt = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sec_r  <= SEC_COMMON;
      left_r <= '0;
      hold_r <= '0;
    end else if (accept) begin
      if (in_item.end_of_message) begin
        pos_r  <= '0;
        sec_r  <= SEC_COMMON;
        left_r <= '0;
        hold_r <= '0;
      end else begin
        pos_r  <= pos_nxt;
        sec_r  <= sec_nxt;
        left_r <= left_nxt;
        hold_r <= hold_nxt;
      end
    end
  end

`ifndef SYNTH
  a_done_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    sec_r == SEC_DONE |-> left_r == '0)
    else $error("front: done section with a nonzero byte count");
  a_eom_resets: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.end_of_message |=> sec_r == SEC_COMMON && pos_r == '0)
    else $error("front: end of message did not return to the common header");
`endif

endmodule

// ===== rtl/pecmp_cmd_queue.sv =====
// Four-entry queue of classified bytes between the front and the back.
module pecmp_cmd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pecmp_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output pecmp_pkg::cmd_t pop_cmd,
  output logic            empty
);
  import pecmp_pkg::*;

  cmd_t                  mem_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wptr_r, rptr_r;
  logic [CMDQ_PTR_W:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !full && !(pop && !empty)) begin
      cnt_nxt = cnt_r + (CMDQ_PTR_W+1)'(1);
    end else if (!(push && !full) && pop && !empty) begin
      cnt_nxt = cnt_r - (CMDQ_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push && !full) begin
        wptr_r <= wptr_r + CMDQ_PTR_W'(1);
      end
      if (pop && !empty) begin
        rptr_r <= rptr_r + CMDQ_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/pecmp_back.sv =====
// Back end: applies field writes and queues finished results for the consumer.
module pecmp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_empty,
  input  pecmp_pkg::cmd_t      cmd,
  output logic                 cmd_pop,
  output logic                 empty,
  input  logic                 pop,
  output pecmp_pkg::out_item_t out_item
);
  import pecmp_pkg::*;

  logic [V7_W-1:0]   type_r, fmt_r, req_r;
  logic [2*ID_W-1:0] id_r;
  logic [WORD_W-1:0] hlen_r, nch_r, cnum_r, dlen_r;

  logic [V7_W-1:0]   type_nxt, fmt_nxt, req_nxt;
  logic [2*ID_W-1:0] id_nxt;
  logic [WORD_W-1:0] hlen_nxt, nch_nxt, cnum_nxt, dlen_nxt;

  out_item_t             res;
  out_item_t             ob_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] ob_wptr_r, ob_rptr_r;
  logic [OUTQ_PTR_W:0]   ob_cnt_r;
  logic                  ob_full;

  assign ob_full  = (ob_cnt_r == (OUTQ_PTR_W+1)'(OUTQ_DEPTH));
  assign cmd_pop  = !cmd_empty && !ob_full;
  assign empty    = (ob_cnt_r == '0);
  assign out_item = ob_r[ob_rptr_r];

  always_comb begin
    type_nxt = type_r;
    fmt_nxt  = fmt_r;
    req_nxt  = req_r;
    id_nxt   = id_r;
    hlen_nxt = hlen_r;
    nch_nxt  = nch_r;
    cnum_nxt = cnum_r;
    dlen_nxt = dlen_r;
    unique case (cmd.op)
      OP_NONE: ;
      OP_TYPE: type_nxt = cmd.op_val[V7_W-1:0];
      OP_FMT:  fmt_nxt  = cmd.op_val[V7_W-1:0];
      OP_ID:   id_nxt[cmd.op_idx*V7_W +: V7_W] = cmd.op_val[V7_W-1:0];
      OP_REQ:  req_nxt  = cmd.op_val[V7_W-1:0];
      OP_HLEN: hlen_nxt = cmd.op_val;
      OP_NCH:  nch_nxt  = cmd.op_val;
      OP_CNUM: cnum_nxt = cmd.op_val;
      OP_DLEN: dlen_nxt = cmd.op_val;
      default: ;
    endcase
    res.byte_kind      = cmd.byte_kind;
    res.payload_byte   = cmd.payload_byte;
    res.status         = cmd.status;
    res.message_type   = type_nxt;
    res.message_format = fmt_nxt;
    res.source_id      = id_nxt[ID_W-1:0];
    res.dest_id        = id_nxt[2*ID_W-1:ID_W];
    res.request_id     = req_nxt;
    res.header_length  = hlen_nxt;
    res.chunk_count    = nch_nxt;
    res.chunk_number   = cnum_nxt;
    res.data_length    = dlen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r <= '0;
      fmt_r  <= '0;
      req_r  <= '0;
      id_r   <= '0;
      hlen_r <= '0;
      nch_r  <= '0;
      cnum_r <= '0;
      dlen_r <= '0;
    end else if (cmd_pop) begin
      // The closing byte still reports its fields; the next message starts clean.
      if (cmd.eom) begin
        type_r <= '0;
        fmt_r  <= '0;
        req_r  <= '0;
        id_r   <= '0;
        hlen_r <= '0;
        nch_r  <= '0;
        cnum_r <= '0;
        dlen_r <= '0;
      end else begin
        type_r <= type_nxt;
        fmt_r  <= fmt_nxt;
        req_r  <= req_nxt;
        id_r   <= id_nxt;
        hlen_r <= hlen_nxt;
        nch_r  <= nch_nxt;
        cnum_r <= cnum_nxt;
        dlen_r <= dlen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      ob_r[ob_wptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wptr_r <= '0;
      ob_rptr_r <= '0;
      ob_cnt_r  <= '0;
    end else begin
      if (cmd_pop) begin
        ob_wptr_r <= ob_wptr_r + OUTQ_PTR_W'(1);
      end
      if (pop && !empty) begin
        ob_rptr_r <= ob_rptr_r + OUTQ_PTR_W'(1);
      end
      if (cmd_pop && !(pop && !empty)) begin
        ob_cnt_r <= ob_cnt_r + (OUTQ_PTR_W+1)'(1);
      end else if (!cmd_pop && pop && !empty) begin
        ob_cnt_r <= ob_cnt_r - (OUTQ_PTR_W+1)'(1);
      end
    end
  end

`ifndef SYNTH
  a_ob_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ob_cnt_r <= (OUTQ_PTR_W+1)'(OUTQ_DEPTH))
    else $error("back: result buffer count out of range");
  a_eom_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop && cmd.eom |=> id_r == '0 && dlen_r == '0 && type_r == '0 && req_r == '0)
    else $error("back: fields not cleared after the closing transaction");
  a_pop_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !ob_full && !cmd_empty)
    else $error("back: took a transaction without room for its result");
`endif

endmodule

// ===== rtl/pe_chunked_message_parser_core.sv =====
// Top level of the property-exchange chunked message parser.
// Takes one message byte per transaction and returns one result per byte: the
// byte's section, the byte itself, the end status and every field decoded so
// far. It sustains one byte per clock cycle while the consumer keeps taking
// results: the front classifies a byte in the cycle it is accepted and the
// back applies its field write as it pops the byte from the queue. A result
// passes the queue and then the registered result buffer on its way out; a
// four-entry queue between front and back and a two-entry result buffer let
// either side stall without stopping the other. No clearing pass after reset.
module pe_chunked_message_parser_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  pecmp_pkg::in_item_t  in_item,
  output logic                 empty,
  input  logic                 pop,
  output pecmp_pkg::out_item_t out_item
);
  import pecmp_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic q_empty;
  logic q_pop;
  logic accept;

  assign accept = push && !full;

  pecmp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_item),
    .cmd     (front_cmd)
  );

  pecmp_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (front_cmd),
    .full     (full),
    .pop      (q_pop),
    .pop_cmd  (back_cmd),
    .empty    (q_empty)
  );

  pecmp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (q_empty),
    .cmd       (back_cmd),
    .cmd_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule
